// ===== rtl/fdsq_pkg.sv =====
package fdsq_pkg;

  // counted width of one slice and width of the family difference
  localparam int SLICE_BITS = 64;
  localparam int DIFF_BITS  = 24;

  // popcount width and signed per-slice delta width
  localparam int CNT_W   = $clog2(SLICE_BITS + 1);
  localparam int DELTA_W = CNT_W + 1;

  // work queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified slice as it travels from front to back
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      close;
    logic                      emit;
  } slice_item_t;

endpackage

// ===== rtl/fdsq_front.sv =====
module fdsq_front (
  input  logic [63:0]          affected_word_i,
  input  logic [63:0]          unaffected_word_i,
  input  logic [63:0]          genotype_word_i,
  input  logic                 family_end_i,
  input  logic                 batch_end_i,
  output fdsq_pkg::slice_item_t item_o
);

  function automatic logic [fdsq_pkg::CNT_W-1:0] count_ones(
    input logic [fdsq_pkg::SLICE_BITS-1:0] w
  );
    logic [fdsq_pkg::CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < fdsq_pkg::SLICE_BITS; k++) begin
      n = n + fdsq_pkg::CNT_W'(w[k]);
    end
    return n;
  endfunction

  logic [fdsq_pkg::SLICE_BITS-1:0] aff_hit;
  logic [fdsq_pkg::SLICE_BITS-1:0] unaff_hit;
  logic [fdsq_pkg::CNT_W-1:0]      gain;
  logic [fdsq_pkg::CNT_W-1:0]      loss;

  // only the low slice bits count
  assign aff_hit   = affected_word_i[fdsq_pkg::SLICE_BITS-1:0]
                   & genotype_word_i[fdsq_pkg::SLICE_BITS-1:0];
  assign unaff_hit = unaffected_word_i[fdsq_pkg::SLICE_BITS-1:0]
                   & genotype_word_i[fdsq_pkg::SLICE_BITS-1:0];
  assign gain      = count_ones(aff_hit);
  assign loss      = count_ones(unaff_hit);

  always_comb begin
    item_o.delta = $signed({1'b0, gain}) - $signed({1'b0, loss});
    // batch end closes the open family too
    item_o.close = family_end_i | batch_end_i;
    item_o.emit  = batch_end_i;
  end

endmodule

// ===== rtl/fdsq_queue.sv =====
module fdsq_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  fdsq_pkg::slice_item_t push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output fdsq_pkg::slice_item_t pop_item_o
);

  fdsq_pkg::slice_item_t             entry_q [fdsq_pkg::QUEUE_DEPTH];
  logic [fdsq_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [fdsq_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [fdsq_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              push;
  logic                              pop;

  assign push_ready_o = (count_q != fdsq_pkg::QCNT_W'(fdsq_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == fdsq_pkg::QPTR_W'(fdsq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == fdsq_pkg::QPTR_W'(fdsq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fdsq_pkg::QCNT_W'(fdsq_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/fdsq_back.sv =====
module fdsq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  fdsq_pkg::slice_item_t item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           sum_d_squared_o
);

  localparam int SUM_W  = fdsq_pkg::DIFF_BITS + 1;
  localparam int PROD_W = 2 * fdsq_pkg::DIFF_BITS;
  localparam logic signed [SUM_W-1:0] DiffLimit =
    SUM_W'((64'd1 << (fdsq_pkg::DIFF_BITS - 1)) - 64'd1);

  logic                                     advance;
  logic                                     take;
  logic signed [SUM_W-1:0]                  diff_sum;
  logic signed [fdsq_pkg::DIFF_BITS-1:0]    diff_sat;
  logic signed [PROD_W-1:0]                 prod;
  logic [31:0]                              sum_new;

  // stage 1: running family difference
  logic signed [fdsq_pkg::DIFF_BITS-1:0]    diff_q;
  // stage 2: closed difference waiting to be squared
  logic                                     v2_q, c2_q, e2_q;
  logic signed [fdsq_pkg::DIFF_BITS-1:0]    d2_q;
  // stage 3: square waiting to be summed
  logic                                     v3_q, c3_q, e3_q;
  logic [31:0]                              sq_q;
  // accumulator and result register
  logic [31:0]                              sum_q;
  logic                                     out_valid_q;
  logic [31:0]                              out_data_q;

  // whole pipe moves unless a result sits untaken
  assign advance      = !(out_valid_q && !out_ready_i);
  assign item_ready_o = advance;
  assign take         = advance & item_valid_i;

  assign diff_sum = SUM_W'(diff_q) + SUM_W'(item_i.delta);

  always_comb begin
    if (diff_sum > DiffLimit) begin
      diff_sat = fdsq_pkg::DIFF_BITS'(DiffLimit);
    end else if (diff_sum < -DiffLimit) begin
      diff_sat = fdsq_pkg::DIFF_BITS'(-DiffLimit);
    end else begin
      diff_sat = fdsq_pkg::DIFF_BITS'(diff_sum);
    end
  end

  assign prod    = d2_q * d2_q;
  assign sum_new = sum_q + (c3_q ? sq_q : 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q      <= '0;
      sum_q       <= '0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v2_q <= take;
      v3_q <= v2_q;
      if (take) begin
        diff_q <= item_i.close ? '0 : diff_sat;
      end
      if (v3_q) begin
        sum_q <= e3_q ? 32'd0 : sum_new;
      end
      out_valid_q <= v3_q & e3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (take) begin
        d2_q <= diff_sat;
        c2_q <= item_i.close;
        e2_q <= item_i.emit;
      end
      sq_q <= 32'($unsigned(prod));
      c3_q <= c2_q;
      e3_q <= e2_q;
      if (v3_q && e3_q) begin
        out_data_q <= sum_new;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sum_d_squared_o = out_data_q;

  a_diff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (diff_q <= fdsq_pkg::DIFF_BITS'(DiffLimit)) &&
    (diff_q >= fdsq_pkg::DIFF_BITS'(-DiffLimit)))
    else $error("family difference left saturation range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(v3_q && e3_q))
    else $error("result raised without a batch end in the last stage");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(sum_q) && $stable(diff_q)))
    else $error("accumulator state moved during stall");

endmodule

// ===== rtl/family_d_squared_popcount_accumulator.sv =====
// family d-squared accumulator: each input beat carries one slice of a
// family's affected mask, unaffected mask and a high-risk genotype bitset.
// the front counts ones in (affected & genotype) and (unaffected & genotype)
// and pushes their signed difference, with the family/batch end marks, into
// a four-entry queue. the back adds the difference into a running family
// value that saturates at +/-(2^(DIFF_BITS-1)-1); on a family end (or batch
// end) the value is squared on a 24x24 multiplier, added modulo 2^32 to the
// running sum and cleared. a batch end emits the sum as one output beat and
// clears it; all other beats produce no output. one beat is accepted per
// cycle while the queue has room; the back also consumes one beat per cycle
// while no result waits untaken. a batch-end beat taken from the queue
// passes the stage-2 and stage-3 registers to the result register, which
// holds the back pipe while it waits on out_ready_i; the queue keeps the
// input side open for up to four more beats during such a stall.
module family_d_squared_popcount_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] affected_word_i,
  input  logic [63:0] unaffected_word_i,
  input  logic [63:0] genotype_word_i,
  input  logic        family_end_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_d_squared_o
);

  fdsq_pkg::slice_item_t front_item;
  fdsq_pkg::slice_item_t back_item;
  logic                  back_valid;
  logic                  back_ready;

  // popcount and classify the incoming beat
  fdsq_front u_front (
    .affected_word_i   (affected_word_i),
    .unaffected_word_i (unaffected_word_i),
    .genotype_word_i   (genotype_word_i),
    .family_end_i      (family_end_i),
    .batch_end_i       (batch_end_i),
    .item_o            (front_item)
  );

  // decouples input acceptance from result backpressure
  fdsq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  // saturating difference, square, sum and result register
  fdsq_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (back_valid),
    .item_ready_o    (back_ready),
    .item_i          (back_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sum_d_squared_o (sum_d_squared_o)
  );

endmodule
